// ===== hdl/svt_pkg.sv =====
// ----------------------------------------------------------------------------
// svt_pkg
// Request and response types, action and status codes and sequencer states
// shared by the sorted value table.
// ----------------------------------------------------------------------------
package svt_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
        logic [3:0]         position;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         entry_count;
        logic signed [31:0] read_value;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_PUT,
        S_REM_SCAN,
        S_RD_WAIT,
        S_FINISH
    } state_t;

endpackage

// ===== hdl/svt_mem.sv =====
// ----------------------------------------------------------------------------
// svt_mem
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module svt_mem
    import svt_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic signed [31:0]  wdata,
    input  logic [AW-1:0]       raddr,
    output logic signed [31:0]  rdata
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/svt_ctrl.sv =====
// ----------------------------------------------------------------------------
// svt_ctrl
// Sequencer: scans the entry store one entry per cycle, shifting entries up
// for insert and down for remove, and builds the response.
// ----------------------------------------------------------------------------
module svt_ctrl
    import svt_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1),
    localparam int PW = (CW > 4) ? CW : 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  req_t                req,
    output logic                done,
    input  logic                take,
    output rsp_t                result,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output logic signed [31:0]  mem_wdata,
    output logic [AW-1:0]       mem_raddr,
    input  logic signed [31:0]  mem_rdata
);

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               found_reg, found_next;
    logic signed [31:0] val_reg, val_next;
    logic [1:0]         status_reg, status_next;
    logic signed [31:0] rv_reg, rv_next;

    logic [CW-1:0]      cnt_dec;
    logic [CW-1:0]      idx_dec;
    logic [CW-1:0]      idx_dec2;
    logic [CW-1:0]      idx_inc;
    logic [PW-1:0]      pos_ext;
    logic [PW-1:0]      cnt_ext;
    logic               hit;

    assign cnt_dec  = count_reg - 1'b1;
    assign idx_dec  = idx_reg - 1'b1;
    assign idx_dec2 = idx_reg - 2'd2;
    assign idx_inc  = idx_reg + 1'b1;
    assign pos_ext  = PW'(req.position);
    assign cnt_ext  = PW'(count_reg);
    assign hit      = (mem_rdata == val_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        rv_reg     <= rv_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        val_next    = val_reg;
        status_next = status_reg;
        rv_next     = rv_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg[AW-1:0];
        mem_wdata   = val_reg;
        mem_raddr   = '0;
        req_stall   = (state_reg != S_IDLE);
        done        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    val_next    = req.value;
                    status_next = ST_OK;
                    rv_next     = '0;
                    case (req.action)
                        ACT_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_FINISH;
                            end
                            else if (count_reg == '0)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = req.value;
                                count_next = CW'(1);
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                // scan from the top entry downward
                                mem_raddr  = cnt_dec[AW-1:0];
                                idx_next   = count_reg;
                                state_next = S_INS_SCAN;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                mem_raddr  = '0;
                                idx_next   = '0;
                                found_next = 1'b0;
                                state_next = S_REM_SCAN;
                            end
                        end
                        ACT_READ:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                mem_raddr  = pos_ext[AW-1:0];
                                state_next = S_RD_WAIT;
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                                state_next  = S_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_INS_SCAN:
            begin
                // rdata holds entry idx-1
                if (!(mem_rdata < val_reg))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg[AW-1:0];
                    mem_wdata = mem_rdata;
                    idx_next  = idx_dec;
                    if (idx_reg == CW'(1))
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        mem_raddr = idx_dec2[AW-1:0];
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = idx_reg[AW-1:0];
                    mem_wdata  = val_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_FINISH;
                end
            end

            S_INS_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0];
                mem_wdata  = val_reg;
                count_next = count_reg + 1'b1;
                state_next = S_FINISH;
            end

            S_REM_SCAN:
            begin
                // rdata holds entry idx; once the match is passed, shift down
                if (found_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_dec[AW-1:0];
                    mem_wdata = mem_rdata;
                end
                found_next = found_reg | hit;
                if (idx_inc == count_reg)
                begin
                    if (found_reg | hit)
                    begin
                        count_next = cnt_dec;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_raddr = idx_inc[AW-1:0];
                    idx_next  = idx_inc;
                end
            end

            S_RD_WAIT:
            begin
                rv_next    = mem_rdata;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                done = 1'b1;
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result.status      = status_reg;
    assign result.entry_count = 5'(count_reg);
    assign result.read_value  = rv_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds table depth");

    a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS_PUT |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert at head did not grow the count");

    a_rem_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REM_SCAN && mem_we) |-> found_reg)
        else $error("remove shifted entries before the match");

    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD_WAIT |-> $past(state_reg) == S_IDLE)
        else $error("read wait not entered from idle");

endmodule

// ===== hdl/sorted_value_table_core.sv =====
// ----------------------------------------------------------------------------
// sorted_value_table_core
// Sorted table of up to DEPTH signed 32-bit values with insert, remove and
// positional read.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid / req_stall / req, responses leave on
//   rsp_valid / rsp_stall / rsp. A transfer happens at a clock edge with
//   valid high and stall low. Every request gives exactly one response.
//   Insert scans the stored entries from the top down, moving each entry
//   not smaller than the new value up one slot; remove scans from the
//   bottom up and moves entries above the match down one slot. Both go
//   through the single entry memory at one entry per cycle. The next
//   request is taken once the sequencer has handed its response to the
//   output register. Reset empties the table at once; no memory clearing
//   pass is needed. When the receiver stalls, the response holds in the
//   output register while the next request is already taken and worked
//   on; its response waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module sorted_value_table_core
    import svt_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic signed [31:0] mem_rdata;
    logic               done;
    logic               load;
    rsp_t               result;
    rsp_t               rsp_reg;
    logic               rsp_valid_reg, rsp_valid_next;

    svt_mem #(.DEPTH(DEPTH)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    svt_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .done      (done),
        .take      (load),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // load when the output register is empty or being drained
    assign load = done && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
